>>> rtl/tam_pkg.sv
`timescale 1ns / 1ps

package tam_pkg;

   // field and register widths
   localparam int CHANNEL_BITS   = 3;
   localparam int PERIOD_BITS    = 16;
   localparam int STEP_BITS      = 32;
   localparam int DEPTH_BITS     = 17;
   localparam int SINE_BITS      = 17;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   // default values for the top level parameters
   localparam int MAX_CHANNELS_DEF   = 8;
   localparam int SINE_ADDR_BITS_DEF = 10;
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int QUEUE_DEPTH_DEF    = 4;

   // register reset values
   localparam logic [PERIOD_BITS-1:0] PERIOD_LEN_RESET = 16'd11025;
   localparam logic [STEP_BITS-1:0]   PHASE_STEP_RESET = 32'd389566;
   localparam logic [DEPTH_BITS-1:0]  DEPTH_Q16_RESET  = 17'd32768;

   // fixed point constants
   localparam logic [SINE_BITS-1:0]  UNITY_Q16    = 17'h10000;
   localparam logic [STEP_BITS-1:0]  QUARTER_TURN = 32'h4000_0000;
   localparam logic [32:0]           UNITY_Q32    = 33'h1_0000_0000;
   localparam logic [63:0]           HALF_PI_Q62  = 64'h6487_ED51_10B4_611A;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PERIOD_LEN = 2'd0,
      CSR_PHASE_STEP = 2'd1,
      CSR_DEPTH_Q16  = 2'd2
   } csr_index_type;

   // live configuration handed to the front and back
   typedef struct packed {
      logic [PERIOD_BITS-1:0] period_len;
      logic [STEP_BITS-1:0]   phase_step;
      logic [DEPTH_BITS-1:0]  depth_q16;
   } cfg_type;

   // (a * b) >> 62, kept to 64 bits
   function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[125:62];
   endfunction

   // divide a series term by (2n+2)(2n+3)
   function automatic logic [63:0] series_div(logic [63:0] x, int n);
      logic [63:0] q;
      case (n)
         0:       q = x / 6;
         1:       q = x / 20;
         2:       q = x / 42;
         3:       q = x / 72;
         4:       q = x / 110;
         5:       q = x / 156;
         6:       q = x / 210;
         7:       q = x / 272;
         8:       q = x / 342;
         9:       q = x / 420;
         10:      q = x / 506;
         11:      q = x / 600;
         default: q = x / 702;
      endcase
      return q;
   endfunction

   // quarter-wave sine entry k, 16 fractional bits, rounded; used at elaboration
   function automatic logic [SINE_BITS-1:0] sine_entry(int k, int addr_bits);
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] sum;
      t    = mul_q62(HALF_PI_Q62, 64'(k) << (62 - addr_bits));
      t2   = mul_q62(t, t);
      term = t;
      pos  = '0;
      neg  = '0;
      for (int n = 0; n < 13; n++) begin
         if ((n % 2) == 0) pos = pos + term;
         else neg = neg + term;
         term = series_div(mul_q62(term, t2), n);
      end
      sum = (pos - neg) + (64'd1 << 45);
      return sum[62:46];
   endfunction

endpackage

>>> rtl/tam_queue.sv
`timescale 1ns / 1ps

module tam_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import tam_pkg::*;

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != COUNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset) count_ff <= COUNT_BITS'(DEPTH))
      else $error("queue fill count above depth");
   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");
`endif

endmodule

>>> rtl/tam_front.sv
`timescale 1ns / 1ps

module tam_front #(
   parameter int MAX_CHANNELS   = 8,
   parameter int SINE_ADDR_BITS = 10,
   parameter int SAMPLE_BITS    = 24,
   parameter int ENTRY_BITS     = 39
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tam_pkg::cfg_type                    cfg,
   input  logic                                cfg_clear,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [tam_pkg::CHANNEL_BITS-1:0]    in_channel,
   input  logic [SAMPLE_BITS-1:0]              in_sample,
   output logic                                push_valid,
   input  logic                                push_ready,
   output logic [ENTRY_BITS-1:0]               push_data
);
   import tam_pkg::*;

   localparam int IDX_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   logic [PERIOD_BITS-1:0] count_ff [MAX_CHANNELS];
   logic [STEP_BITS-1:0]   phase_ff [MAX_CHANNELS];
   logic [PERIOD_BITS-1:0] count_in;
   logic [STEP_BITS-1:0]   phase_in;
   logic [PERIOD_BITS-1:0] plen;
   logic [PERIOD_BITS-1:0] count_cur;
   logic [STEP_BITS-1:0]   phase_cur;
   logic [STEP_BITS-1:0]   look;
   logic [IDX_BITS-1:0]    idx;
   logic                   has_state;
   logic                   wrap;
   logic                   negative;
   logic [SAMPLE_BITS-1:0] mag;
   logic                   accept;

   assign in_ready   = push_ready;
   assign push_valid = in_valid;
   assign accept     = in_valid && push_ready;

   // classify the request and step its channel LFO
   always_comb begin
      has_state = (32'(in_channel) < 32'(MAX_CHANNELS));
      idx       = has_state ? IDX_BITS'(in_channel) : '0;
      plen      = (cfg.period_len == '0) ? PERIOD_BITS'(1) : cfg.period_len;
      wrap      = (count_ff[idx] >= plen);
      count_cur = wrap ? '0 : count_ff[idx];
      phase_cur = wrap ? '0 : phase_ff[idx];
      count_in  = count_cur + 1'b1;
      phase_in  = phase_cur + cfg.phase_step;
      look      = phase_cur + QUARTER_TURN;
      // sign and magnitude; the most negative value maps to 2^(n-1) as is
      negative  = in_sample[SAMPLE_BITS-1];
      mag       = negative ? SAMPLE_BITS'(-in_sample) : in_sample;
   end

   assign push_data = {look[STEP_BITS-1 -: SINE_ADDR_BITS], mag, negative, has_state,
                       in_channel};

   // per-channel counters, cleared by reset and by any register write
   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            count_ff[c] <= '0;
            phase_ff[c] <= '0;
         end
      end else if (accept && has_state) begin
         count_ff[idx] <= count_in;
         phase_ff[idx] <= phase_in;
      end
   end

endmodule

>>> rtl/tam_back.sv
`timescale 1ns / 1ps

module tam_back #(
   parameter int SINE_ADDR_BITS = 10,
   parameter int SAMPLE_BITS    = 24,
   parameter int ENTRY_BITS     = 39
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tam_pkg::DEPTH_BITS-1:0]   depth_q16,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  logic [ENTRY_BITS-1:0]            pop_data,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [tam_pkg::CHANNEL_BITS-1:0] out_channel,
   output logic [SAMPLE_BITS-1:0]           out_sample
);
   import tam_pkg::*;

   localparam int ROM_SIZE   = 1 << SINE_ADDR_BITS;
   localparam int SCALE_BITS = SAMPLE_BITS + 33;

   typedef logic [SINE_BITS-1:0] rom_type [ROM_SIZE];

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k < ROM_SIZE; k++) r[k] = sine_entry(k, SINE_ADDR_BITS);
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ENV   = 4'b0010,
      ST_GAIN  = 4'b0100,
      ST_SCALE = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [ENTRY_BITS-1:0]   item_ff;
   logic [SINE_BITS-1:0]    env_ff;
   logic [33:0]             prod_ff, prod_in;
   logic [SCALE_BITS-1:0]   scale_ff, scale_in;
   logic                    out_valid_ff, out_valid_in;
   logic [CHANNEL_BITS-1:0] out_channel_ff;
   logic [SAMPLE_BITS-1:0]  out_sample_ff, out_sample_in;

   logic [CHANNEL_BITS-1:0]   item_channel;
   logic                      item_has_state;
   logic                      item_negative;
   logic [SAMPLE_BITS-1:0]    item_mag;
   logic [SINE_ADDR_BITS-1:0] pop_addr;
   logic [DEPTH_BITS-1:0]     depth_sat;
   logic [32:0]               gain;
   logic [SAMPLE_BITS-1:0]    res;
   logic                      load_out;

   // queue entry fields, lowest first: channel, has_state, negative, mag, addr
   assign item_channel   = item_ff[CHANNEL_BITS-1:0];
   assign item_has_state = item_ff[CHANNEL_BITS];
   assign item_negative  = item_ff[CHANNEL_BITS+1];
   assign item_mag       = item_ff[CHANNEL_BITS+2 +: SAMPLE_BITS];
   assign pop_addr       = pop_data[CHANNEL_BITS+2+SAMPLE_BITS +: SINE_ADDR_BITS];

   // gain arithmetic
   always_comb begin
      depth_sat = (depth_q16 > DEPTH_BITS'(UNITY_Q16)) ? DEPTH_BITS'(UNITY_Q16) : depth_q16;
      prod_in   = 34'(depth_sat) * 34'(UNITY_Q16 - env_ff);
      gain      = item_has_state ? (UNITY_Q32 - 33'(prod_ff >> 1)) : UNITY_Q32;
      scale_in  = SCALE_BITS'(item_mag) * SCALE_BITS'(gain);
      res       = scale_ff[32 +: SAMPLE_BITS];
      out_sample_in = item_negative ? SAMPLE_BITS'(-res) : res;
   end

   // sequencer: one item through lookup, gain and scale
   always_comb begin
      state_in  = state_ff;
      pop_ready = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) state_in = ST_ENV;
         end
         ST_ENV:  state_in = ST_GAIN;
         ST_GAIN: state_in = ST_SCALE;
         ST_SCALE: begin
            if (!out_valid_ff || out_ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && out_ready) out_valid_in = 1'b0;
      if (load_out) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers and sine lookup
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && pop_valid) begin
         item_ff <= pop_data;
         env_ff  <= SINE_ROM[pop_addr];
      end
      if (state_ff == ST_ENV) prod_ff <= prod_in;
      if (state_ff == ST_GAIN) scale_ff <= scale_in;
      if (load_out) begin
         out_channel_ff <= item_channel;
         out_sample_ff  <= out_sample_in;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_channel = out_channel_ff;
   assign out_sample  = out_sample_ff;

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) |-> (res <= item_mag))
      else $error("scaled magnitude above input magnitude");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GAIN) |-> (gain <= UNITY_Q32))
      else $error("gain above unity");
`endif

endmodule

>>> rtl/tremolo_amplitude_modulator.sv
`timescale 1ns / 1ps

// Tremolo for interleaved audio, one LFO per channel.
// req_ carries a request: channel and signed sample. rsp_ returns one result
// per request, in order: the channel and the sample scaled by the LFO gain.
// csr_ is a write-only register port (index 0 period_len, 1 phase_step,
// 2 depth_q16); a write to any of them restarts every channel's LFO, and it is
// to be done only while no request is in flight.
// The back-end sequencer takes a new request only after the last one has
// gone through sine lookup, depth multiply, sample multiply and output load.
// A taken request waits in the queue until the back end is free, then goes
// through these steps before rsp_tvalid rises. The front takes requests every
// cycle into a 4-entry queue, so short bursts are absorbed; req_tready drops
// only when the queue is full. When rsp_tready is low the result holds in the
// output register, the back end waits with the next result, and the queue
// keeps filling. Reset (synchronous) restores register defaults and clears all
// LFO state at once; no clearing pass follows.
module tremolo_amplitude_modulator #(
   parameter int MAX_CHANNELS   = tam_pkg::MAX_CHANNELS_DEF,
   parameter int SINE_ADDR_BITS = tam_pkg::SINE_ADDR_BITS_DEF,
   parameter int SAMPLE_BITS    = tam_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request: channel [2:0], sample_in above it, zero padded
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((tam_pkg::CHANNEL_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // result: channel_out [2:0], sample_out above it, zero padded
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((tam_pkg::CHANNEL_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                   csr_wen,
   input  logic [tam_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [tam_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import tam_pkg::*;

   localparam int DATA_BITS  = ((CHANNEL_BITS + SAMPLE_BITS + 7) / 8) * 8;
   localparam int PAD_BITS   = DATA_BITS - CHANNEL_BITS - SAMPLE_BITS;
   localparam int ENTRY_BITS = SINE_ADDR_BITS + SAMPLE_BITS + 2 + CHANNEL_BITS;

   cfg_type                 cfg_ff, cfg_in;
   logic                    cfg_clear;
   logic                    push_valid;
   logic                    push_ready;
   logic [ENTRY_BITS-1:0]   push_data;
   logic                    pop_valid;
   logic                    pop_ready;
   logic [ENTRY_BITS-1:0]   pop_data;
   logic [CHANNEL_BITS-1:0] channel_out;
   logic [SAMPLE_BITS-1:0]  sample_out;

   // register write decode
   always_comb begin
      cfg_in    = cfg_ff;
      cfg_clear = 1'b0;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_PERIOD_LEN: begin
               cfg_in.period_len = csr_wdata[PERIOD_BITS-1:0];
               cfg_clear         = 1'b1;
            end
            CSR_PHASE_STEP: begin
               cfg_in.phase_step = csr_wdata[STEP_BITS-1:0];
               cfg_clear         = 1'b1;
            end
            CSR_DEPTH_Q16: begin
               cfg_in.depth_q16 = csr_wdata[DEPTH_BITS-1:0];
               cfg_clear        = 1'b1;
            end
            default: cfg_clear = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_len <= PERIOD_LEN_RESET;
         cfg_ff.phase_step <= PHASE_STEP_RESET;
         cfg_ff.depth_q16  <= DEPTH_Q16_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tam_front #(
      .MAX_CHANNELS  (MAX_CHANNELS),
      .SINE_ADDR_BITS(SINE_ADDR_BITS),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .ENTRY_BITS    (ENTRY_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cfg_clear (cfg_clear),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_channel(req_tdata[CHANNEL_BITS-1:0]),
      .in_sample (req_tdata[CHANNEL_BITS +: SAMPLE_BITS]),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data)
   );

   tam_queue #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(QUEUE_DEPTH_DEF)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   tam_back #(
      .SINE_ADDR_BITS(SINE_ADDR_BITS),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .ENTRY_BITS    (ENTRY_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .depth_q16  (cfg_ff.depth_q16),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_channel(channel_out),
      .out_sample (sample_out)
   );

   assign rsp_tdata = {{PAD_BITS{1'b0}}, sample_out, channel_out};

endmodule
